>>> rtl/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg: shared types and constants of the morphological edge core
// pixel type, cell flag bundle, register map and default dimensions
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int unsigned PIX_W = 8;
    localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

    // configuration register map
    localparam int unsigned CFG_DIM_W = 11;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic REG_IMAGE_WIDTH = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_DIM_W-1:0] RESET_IMAGE_WIDTH = 11'd640;
    localparam logic [CFG_DIM_W-1:0] RESET_IMAGE_HEIGHT = 11'd480;

    // default frame limits
    localparam int unsigned DEF_MAX_WIDTH = 1024;
    localparam int unsigned DEF_MAX_HEIGHT = 1024;

    // output queue depth
    localparam int unsigned FIFO_DEPTH = 4;

    typedef logic [PIX_W-1:0] t_pixel;

    // per-cell status of the value the cell will hold after this cycle
    typedef struct packed {
        logic not_full;
        logic not_zero;
    } t_cell_flags;

endpackage

>>> rtl/mec_ram.sv
// ----------------------------------------------------------------------------
// mec_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mec_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mec_cell.sv
// ----------------------------------------------------------------------------
// mec_cell: one window cell
// holds one pixel, takes its neighbour's pixel on a shift and reports
// whether its next value is full white or black
// ----------------------------------------------------------------------------
module mec_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  mec_pkg::t_pixel       i_d,
    output mec_pkg::t_pixel       o_q,
    output mec_pkg::t_pixel       o_next,
    output mec_pkg::t_cell_flags  o_flags
);
    import mec_pkg::*;

    t_pixel r_q;
    t_pixel n_q;

    // next value: neighbour's pixel on a shift, else hold
    assign n_q = i_en ? i_d : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= PIX_ZERO;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q              = r_q;
    assign o_next           = n_q;
    assign o_flags.not_full = (n_q != PIX_FULL);
    assign o_flags.not_zero = (n_q != PIX_ZERO);

endmodule

>>> rtl/morphological_edge_3x3_core.sv
// ----------------------------------------------------------------------------
// Results trail the input stream by image_width+1 words; the word completing
// a window is registered in the window stage, then queued for output.
// Throughput: one word per clock while the queue has room, set by the single
// read port of each line buffer; a 4-word queue absorbs downstream stalls.
// Reset: counters clear, width/height return to 640/480; line buffers are not
// cleared, as only border results (forced to 255) can see stale contents.
// ----------------------------------------------------------------------------
// morphological_edge_3x3_core: 3x3 morphological gradient on a pixel stream
// two line-buffer rams feed a 3x3 chain of window cells; border pixels give 255
// ----------------------------------------------------------------------------
module morphological_edge_3x3_core #(
    parameter int unsigned MAX_WIDTH  = mec_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = mec_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // [7:0] pixel
    input  logic                            i_s_axis_tuser,  // [0] is_flush
    // output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [7:0]                      o_m_axis_tdata,  // [7:0] edge_pixel
    output logic                            o_m_axis_tlast,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mec_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mec_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mec_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import mec_pkg::*;

    localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
    localparam int unsigned ORW_W  = $clog2(MAX_HEIGHT);
    localparam int unsigned IRW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int unsigned DIMW_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned DIMH_W = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CMPW_W = (DIMW_W > CFG_DIM_W) ? DIMW_W : CFG_DIM_W;
    localparam int unsigned CMPH_W = (DIMH_W > CFG_DIM_W) ? DIMH_W : CFG_DIM_W;
    localparam int unsigned FPTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FCNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration registers
    logic [CFG_DIM_W-1:0] r_cfg_w;
    logic [CFG_DIM_W-1:0] r_cfg_h;
    logic                 cfg_wr;

    // effective frame size
    logic [CMPW_W-1:0]    w_ext;
    logic [CMPH_W-1:0]    h_ext;
    logic [DIMW_W-1:0]    w_eff;
    logic [DIMH_W-1:0]    h_eff;
    logic [COL_W-1:0]     w_last;
    logic [ORW_W-1:0]     h_last;

    // position counters
    logic [COL_W-1:0]     r_in_col;
    logic [IRW_W-1:0]     r_in_row;
    logic [COL_W-1:0]     r_out_col;
    logic [ORW_W-1:0]     r_out_row;

    // input stage decode
    logic                 in_acc;
    logic                 px_exp;
    logic                 go;
    logic                 emit;
    logic                 border;
    logic                 frame_last;

    // window stage
    logic                 r_s1_valid;
    logic                 r_s1_upd;
    logic                 r_s1_emit;
    logic                 r_s1_border;
    logic                 r_s1_last;
    t_pixel               r_s1_pixel;
    logic [COL_W-1:0]     r_s1_col;
    t_pixel               rd_above;
    t_pixel               rd_mid;
    logic                 win_en;

    // window cells
    t_pixel               row_src  [3];
    t_pixel               win_q    [9];
    t_pixel               win_next [9];
    t_cell_flags          win_flags[9];
    logic                 any_not_full;
    logic                 any_not_zero;
    t_pixel               dil;
    t_pixel               ero;
    logic                 push;
    logic                 push_bright;

    // output queue
    logic                 r_fifo_bright [FIFO_DEPTH];
    logic                 r_fifo_last   [FIFO_DEPTH];
    logic [FPTR_W-1:0]    r_wr_ptr;
    logic [FPTR_W-1:0]    r_rd_ptr;
    logic [FCNT_W-1:0]    r_count;
    logic                 pop;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RESET_IMAGE_WIDTH;
            r_cfg_h <= RESET_IMAGE_HEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  r_cfg_w <= pwdata[CFG_DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_h <= pwdata[CFG_DIM_W-1:0];
                default:          r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? APB_DATA_W'(r_cfg_h)
                                                   : APB_DATA_W'(r_cfg_w);

    // clamp dimensions to the supported range
    assign w_ext = CMPW_W'(r_cfg_w);
    assign h_ext = CMPH_W'(r_cfg_h);

    always_comb begin
        if (w_ext < CMPW_W'(3)) begin
            w_eff = DIMW_W'(3);
        end else if (w_ext > CMPW_W'(MAX_WIDTH)) begin
            w_eff = DIMW_W'(MAX_WIDTH);
        end else begin
            w_eff = DIMW_W'(w_ext);
        end
        if (h_ext < CMPH_W'(3)) begin
            h_eff = DIMH_W'(3);
        end else if (h_ext > CMPH_W'(MAX_HEIGHT)) begin
            h_eff = DIMH_W'(MAX_HEIGHT);
        end else begin
            h_eff = DIMH_W'(h_ext);
        end
    end

    assign w_last = COL_W'(w_eff - DIMW_W'(1));
    assign h_last = ORW_W'(h_eff - DIMH_W'(1));

    // input stage: accept, drop early flush words, classify
    assign in_acc     = i_s_axis_tvalid & o_s_axis_tready;
    assign px_exp     = r_in_row < IRW_W'(h_eff);
    assign go         = in_acc & ~(px_exp & i_s_axis_tuser);
    assign emit       = (r_in_row >= IRW_W'(2))
                        || ((r_in_row == IRW_W'(1)) && (r_in_col != '0));
    assign frame_last = (r_out_row == h_last) && (r_out_col == w_last);
    assign border     = (r_out_row == '0) || (r_out_row >= h_last)
                        || (r_out_col == '0) || (r_out_col == w_last);

    // position counters, restarted by any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (go) begin
            if (emit && frame_last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (r_in_col == w_last) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + IRW_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
                if (emit) begin
                    if (r_out_col == w_last) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + ORW_W'(1);
                    end else begin
                        r_out_col <= r_out_col + COL_W'(1);
                    end
                end
            end
        end
    end

    // window stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1_upd    <= px_exp;
            r_s1_emit   <= emit;
            r_s1_border <= border;
            r_s1_last   <= frame_last;
            r_s1_pixel  <= i_s_axis_tdata;
            r_s1_col    <= r_in_col;
        end
    end

    assign win_en = r_s1_valid & r_s1_upd;

    // line buffers: two rows up and one row up
    mec_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .i_clk   (i_clk),
        .i_we    (win_en),
        .i_waddr (r_s1_col),
        .i_wdata (rd_mid),
        .i_re    (go & px_exp),
        .i_raddr (r_in_col),
        .o_rdata (rd_above)
    );

    mec_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_middle (
        .i_clk   (i_clk),
        .i_we    (win_en),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pixel),
        .i_re    (go & px_exp),
        .i_raddr (r_in_col),
        .o_rdata (rd_mid)
    );

    // 3x3 chain of cells, row-major, new column enters at the right
    assign row_src[0] = rd_above;
    assign row_src[1] = rd_mid;
    assign row_src[2] = r_s1_pixel;

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar k = 0; k < 3; k++) begin : g_col
            t_pixel cell_d;
            if (k == 2) begin : g_feed
                assign cell_d = row_src[r];
            end else begin : g_link
                assign cell_d = win_q[r*3 + k + 1];
            end
            mec_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (win_en),
                .i_d     (cell_d),
                .o_q     (win_q[r*3 + k]),
                .o_next  (win_next[r*3 + k]),
                .o_flags (win_flags[r*3 + k])
            );
        end
    end

    // gradient over the eight neighbours of the updated window
    always_comb begin
        any_not_full = 1'b0;
        any_not_zero = 1'b0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                any_not_full = any_not_full | win_flags[i].not_full;
                any_not_zero = any_not_zero | win_flags[i].not_zero;
            end
        end
    end

    assign dil         = any_not_full ? PIX_ZERO : win_next[4];
    assign ero         = any_not_zero ? PIX_FULL : win_next[4];
    assign push        = r_s1_valid & r_s1_emit;
    assign push_bright = r_s1_border | (dil == ero);

    // output queue
    assign pop             = o_m_axis_tvalid & i_m_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = r_fifo_bright[r_rd_ptr] ? PIX_FULL : PIX_ZERO;
    assign o_m_axis_tlast  = r_fifo_last[r_rd_ptr];
    assign o_s_axis_tready = ((FCNT_W + 1)'(r_count) + (FCNT_W + 1)'(r_s1_valid))
                             < (FCNT_W + 1)'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo_bright[r_wr_ptr] <= push_bright;
            r_fifo_last[r_wr_ptr]   <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + FCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - FCNT_W'(1);
            end
        end
    end

endmodule

>>> tb/morphological_edge_3x3_core_tb.sv
// ----------------------------------------------------------------------------
// morphological_edge_3x3_core_tb: self-checking bench for the 3x3 edge core
// drives raster frames and drain words through the input stream, predicts
// edge words from a local copy of the line buffers and window or takes them
// from the directed table, and compares each output word in order; register
// writes and read-backs run between frames over the configuration port
// ----------------------------------------------------------------------------
module morphological_edge_3x3_core_tb;

    import mec_pkg::*;

    localparam int unsigned HALF_PERIOD = 10;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned PHASE_WORDS = 150;
    localparam int unsigned RUN_LIMIT_CYCLES = 400000;
    localparam int unsigned MAX_REPORTS = 40;

    localparam logic IS_FLUSH = 1'b1;
    localparam logic IS_PIXEL = 1'b0;
    localparam logic CHK = 1'b1;
    localparam logic NO_CHK = 1'b0;

    // pixel content styles of a random frame
    localparam int unsigned STYLE_NOISE = 0;
    localparam int unsigned STYLE_BINARY = 1;
    localparam int unsigned STYLE_RUNS = 2;

    typedef enum logic [1:0] {
        STEP_READ,
        STEP_WRITE,
        STEP_WORD
    } t_step_kind;

    // one row of the directed table; value holds the pixel in [7:0] for words
    typedef struct packed {
        t_step_kind            kind;
        logic                  reg_sel;
        logic [CFG_DIM_W-1:0]  value;
        logic                  flush;
        logic                  typed;
        t_pixel                want_edge;
        logic                  want_last;
    } t_dir_step;

    typedef struct {
        t_pixel edge_px;
        logic   last;
    } t_edge_word;

    // directed table: reset values, clamped sizes, two 3x3 frames
    localparam t_dir_step DIRECTED [31] = '{
        '{STEP_READ,  REG_IMAGE_WIDTH,  RESET_IMAGE_WIDTH,  IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_READ,  REG_IMAGE_HEIGHT, RESET_IMAGE_HEIGHT, IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WRITE, REG_IMAGE_WIDTH,  11'd2,              IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 11'd0,              IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        // zero neighbours round a full centre, stray flush mid-frame
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'h0A5, IS_FLUSH, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_PIXEL, CHK,    PIX_ZERO, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'h03C, IS_FLUSH, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_FLUSH, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_FLUSH, CHK,    PIX_FULL, 1'b1},
        // all-full frame, pixel words after the frame act as flushes
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd255, IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_FLUSH, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'h081, IS_PIXEL, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_FLUSH, CHK,    PIX_FULL, 1'b0},
        '{STEP_WORD,  REG_IMAGE_WIDTH,  11'd0,   IS_FLUSH, CHK,    PIX_FULL, 1'b1}
    };

    // clock, reset and block inputs, all known from time zero
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [7:0]             i_s_axis_tdata = 8'd0;   // [7:0] pixel
    logic                   i_s_axis_tuser = 1'b0;   // [0] is_flush
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [7:0]             o_m_axis_tdata;          // [7:0] edge_pixel
    logic                   o_m_axis_tlast;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // predictor state
    logic [CFG_DIM_W-1:0]   width_reg;
    logic [CFG_DIM_W-1:0]   height_reg;
    t_pixel                 line_above [DEF_MAX_WIDTH];
    t_pixel                 line_middle [DEF_MAX_WIDTH];
    t_pixel                 win_px [9];
    int unsigned            next_col;
    int unsigned            next_row;
    int unsigned            next_out;

    t_edge_word             gradient_q [$];

    // pacing and bookkeeping
    int unsigned            send_idle_pct = 0;
    int unsigned            recv_idle_pct = 0;
    int unsigned            hold_len = 0;
    int unsigned            hold_req_id = 0;
    int unsigned            hold_served_id = 0;
    int unsigned            hold_left = 0;
    int unsigned            fail_count = 0;
    int unsigned            words_sent = 0;
    int unsigned            words_ignored = 0;
    int unsigned            results_checked = 0;
    int unsigned            frames_closed = 0;
    int unsigned            cfg_writes = 0;

    morphological_edge_3x3_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int unsigned eff_dim(input logic [CFG_DIM_W-1:0] raw,
                                            input int unsigned hi);
        if (raw < 3) return 3;
        if (raw > hi) return hi;
        return 32'(raw);
    endfunction

    // one input word through the predicted core; returns 1 when a word comes out
    function automatic bit gradient_step(input t_pixel px, input logic flush,
                                         output t_pixel edge_out, output logic last_out);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned orow;
        int unsigned ocol;
        bit pixel_due;
        bit emit;
        bit any_not_full;
        bit any_not_zero;
        t_pixel dil;
        t_pixel ero;
        w = eff_dim(width_reg, DEF_MAX_WIDTH);
        h = eff_dim(height_reg, DEF_MAX_HEIGHT);
        pixel_due = next_row < h;
        edge_out = PIX_FULL;
        last_out = 1'b0;
        // a flush while pixels are still due changes nothing
        if (pixel_due && flush) return 1'b0;
        if (pixel_due) begin
            c = (next_col < w) ? next_col : w - 1;
            for (int r = 0; r < 3; r++) begin
                win_px[r*3] = win_px[r*3+1];
                win_px[r*3+1] = win_px[r*3+2];
            end
            win_px[2] = line_above[c];
            win_px[5] = line_middle[c];
            win_px[8] = px;
            line_above[c] = line_middle[c];
            line_middle[c] = px;
        end
        emit = (next_row >= 2) || (next_row == 1 && next_col >= 1);
        next_col++;
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
        end
        if (!emit) return 1'b0;
        orow = next_out / w;
        ocol = next_out % w;
        if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol == w - 1) begin
            edge_out = PIX_FULL;
        end else begin
            // neighbours only, centre left out
            any_not_full = 1'b0;
            any_not_zero = 1'b0;
            for (int i = 0; i < 9; i++) begin
                if (i != 4) begin
                    if (win_px[i] != PIX_FULL) any_not_full = 1'b1;
                    if (win_px[i] != PIX_ZERO) any_not_zero = 1'b1;
                end
            end
            dil = any_not_full ? PIX_ZERO : win_px[4];
            ero = any_not_zero ? PIX_FULL : win_px[4];
            edge_out = (dil != ero) ? PIX_ZERO : PIX_FULL;
        end
        last_out = (next_out >= w * h - 1);
        if (last_out) begin
            next_col = 0;
            next_row = 0;
            next_out = 0;
        end else begin
            next_out++;
        end
        return 1'b1;
    endfunction

    // offer one word until it is taken, then record its expected result
    task automatic offer_word(input t_pixel px, input logic flush, input logic typed,
                              input t_pixel want_edge, input logic want_last);
        t_edge_word exp_word;
        bit has_result;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= px;
        i_s_axis_tuser <= flush;
        do @(posedge i_clk); while (!o_s_axis_tready);
        has_result = gradient_step(px, flush, exp_word.edge_px, exp_word.last);
        if (typed) begin
            exp_word.edge_px = want_edge;
            exp_word.last = want_last;
            gradient_q.push_back(exp_word);
        end else if (has_result) begin
            gradient_q.push_back(exp_word);
        end
    endtask

    // wait until every predicted word has come out, then let the pipe go quiet
    task automatic settle_results();
        i_s_axis_tvalid <= 1'b0;
        while (gradient_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_check(input logic sel, input logic [CFG_DIM_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {sel, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got !== APB_DATA_W'(want))
            flag_mismatch($sformatf("register %0d read %0d, want %0d", sel, got, want));
    endtask

    // write a register, mirror it in the predictor and read it back
    task automatic cfg_write(input logic sel, input logic [CFG_DIM_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        next_col = 0;
        next_row = 0;
        next_out = 0;
        cfg_writes++;
        @(posedge i_clk);
        cfg_check(sel, val);
    endtask

    // pixels of one frame with random content, stray flushes, then drain words
    task automatic send_frame(input int unsigned npix, input int unsigned drain_len);
        int unsigned style;
        t_pixel base;
        t_pixel px;
        style = $urandom_range(STYLE_NOISE, STYLE_RUNS);
        base = $urandom_range(0, 1) ? PIX_FULL : PIX_ZERO;
        for (int unsigned i = 0; i < npix; i++) begin
            if ($urandom_range(0, 99) < 3) begin
                offer_word(t_pixel'($urandom_range(0, 255)), IS_FLUSH, NO_CHK, PIX_ZERO, 1'b0);
                words_ignored++;
            end
            case (style)
                STYLE_NOISE: px = t_pixel'($urandom_range(0, 255));
                STYLE_BINARY: px = $urandom_range(0, 1) ? PIX_FULL : PIX_ZERO;
                default: begin
                    if ($urandom_range(0, 99) < 8) base = ~base;
                    px = ($urandom_range(0, 99) < 5) ? t_pixel'($urandom_range(0, 255)) : base;
                end
            endcase
            offer_word(px, IS_PIXEL, NO_CHK, PIX_ZERO, 1'b0);
            words_sent++;
        end
        for (int unsigned d = 0; d < drain_len; d++) begin
            offer_word(t_pixel'($urandom_range(0, 255)), logic'($urandom_range(0, 3) != 0),
                       NO_CHK, PIX_ZERO, 1'b0);
            words_sent++;
        end
    endtask

    // output side: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_served_id != hold_req_id) begin
            hold_served_id <= hold_req_id;
            hold_left <= hold_len;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // compare each output word with the oldest prediction
    always @(posedge i_clk) begin
        t_edge_word want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (gradient_q.size() == 0) begin
                flag_mismatch($sformatf("word %0d/%0d with nothing expected",
                                        o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = gradient_q.pop_front();
                results_checked++;
                if (o_m_axis_tlast === 1'b1) frames_closed++;
                if (o_m_axis_tdata !== want.edge_px)
                    flag_mismatch($sformatf("edge_pixel %0d, want %0d",
                                            o_m_axis_tdata, want.edge_px));
                if (o_m_axis_tlast !== want.last)
                    flag_mismatch($sformatf("last_of_frame %0d, want %0d",
                                            o_m_axis_tlast, want.last));
            end
        end
    end

    initial begin
        #(2 * HALF_PERIOD * RUN_LIMIT_CYCLES);
        $display("morphological_edge_3x3_core_tb: FAIL");
        $finish;
    end

    initial begin
        int unsigned phase_words;
        int unsigned w;
        int unsigned h;
        logic [CFG_DIM_W-1:0] w_raw;
        logic [CFG_DIM_W-1:0] h_raw;
        bit need_cfg;
        // predictor after reset
        width_reg = RESET_IMAGE_WIDTH;
        height_reg = RESET_IMAGE_HEIGHT;
        for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            line_above[i] = PIX_ZERO;
            line_middle[i] = PIX_ZERO;
        end
        for (int i = 0; i < 9; i++) win_px[i] = PIX_ZERO;
        next_col = 0;
        next_row = 0;
        next_out = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, sender rarely idle, receiver mostly stalled
        send_idle_pct = 6;
        recv_idle_pct = 75;
        foreach (DIRECTED[k]) begin
            case (DIRECTED[k].kind)
                STEP_READ: cfg_check(DIRECTED[k].reg_sel, DIRECTED[k].value);
                STEP_WRITE: cfg_write(DIRECTED[k].reg_sel, DIRECTED[k].value);
                default: offer_word(DIRECTED[k].value[PIX_W-1:0], DIRECTED[k].flush,
                                    DIRECTED[k].typed, DIRECTED[k].want_edge,
                                    DIRECTED[k].want_last);
            endcase
        end
        settle_results();

        // random frames under three pacing modes
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 75 : 0;
            recv_idle_pct = (mode == 0) ? 75 : (mode == 1) ? 6 : 0;
            if (mode == 2) begin
                settle_results();
                // widest rows with all bits set, clamped height
                cfg_write(REG_IMAGE_WIDTH, 11'h7FF);
                cfg_write(REG_IMAGE_HEIGHT, 11'd2);
                send_frame(DEF_MAX_WIDTH + 12, 0);
                settle_results();
                // narrowest rows, tallest frame
                cfg_write(REG_IMAGE_WIDTH, 11'd0);
                cfg_write(REG_IMAGE_HEIGHT, 11'h7FF);
                send_frame(120, 0);
                settle_results();
                // long output hold-off while words keep coming, fills the core
                cfg_write(REG_IMAGE_WIDTH, 11'd10);
                cfg_write(REG_IMAGE_HEIGHT, 11'd8);
                hold_len <= 150;
                hold_req_id <= hold_req_id + 1;
                send_frame(80, 11);
                settle_results();
            end
            phase_words = words_sent;
            need_cfg = 1'b1;
            while (words_sent - phase_words < PHASE_WORDS) begin
                if (need_cfg || $urandom_range(0, 99) < 40) begin
                    settle_results();
                    case ($urandom_range(0, 9))
                        0: w_raw = CFG_DIM_W'($urandom_range(0, 2));
                        1: w_raw = CFG_DIM_W'($urandom_range(13, 40));
                        default: w_raw = CFG_DIM_W'($urandom_range(3, 12));
                    endcase
                    case ($urandom_range(0, 9))
                        0: h_raw = CFG_DIM_W'($urandom_range(0, 2));
                        1: h_raw = CFG_DIM_W'($urandom_range(9, 14));
                        default: h_raw = CFG_DIM_W'($urandom_range(3, 8));
                    endcase
                    if ($urandom_range(0, 1)) begin
                        cfg_write(REG_IMAGE_WIDTH, w_raw);
                        cfg_write(REG_IMAGE_HEIGHT, h_raw);
                    end else begin
                        cfg_write(REG_IMAGE_HEIGHT, h_raw);
                        cfg_write(REG_IMAGE_WIDTH, w_raw);
                    end
                    need_cfg = 1'b0;
                end
                w = eff_dim(width_reg, DEF_MAX_WIDTH);
                h = eff_dim(height_reg, DEF_MAX_HEIGHT);
                // now and then a frame is cut short by a register write
                if ($urandom_range(0, 9) == 0) begin
                    send_frame($urandom_range(1, w * h - 1), 0);
                    need_cfg = 1'b1;
                end else begin
                    send_frame(w * h, w + 1);
                end
            end
        end
        settle_results();

        $display("run covered %0d words (%0d stray flushes), %0d edge words in %0d frames",
                 words_sent, words_ignored, results_checked, frames_closed);
        $display("%0d register writes, rows of 3 to 1024 pixels, three stall patterns",
                 cfg_writes);
        if (fail_count == 0 && gradient_q.size() == 0) begin
            $display("morphological_edge_3x3_core_tb: PASS");
        end else begin
            $display("morphological_edge_3x3_core_tb: FAIL");
        end
        $finish;
    end

endmodule
